### sv/scv_pkg.sv
// Shared widths, constants, arctangent table and stage types of the spline velocity block.
`default_nettype none
package scv_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int TRIG_ITERATIONS_DEF = 16;

    localparam int XW  = 33;   // CORDIC x/y, Q30
    localparam int CZW = 35;   // CORDIC residual angle, Q30
    localparam int QW  = 18;   // quotient bits, top bit flags overflow
    localparam int DW  = 49;   // divisor width
    localparam int RW  = 67;   // partial remainder width

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_GAIN    = 64'sd652032874;
    localparam longint Q30_SQRT2   = 64'sd1518500250;
    localparam longint Q30_CHALF   = 64'sd663608942;
    localparam longint Q30_DHALF   = 64'sd410132882;
    localparam int     VEL_MAX     = 32768;
    localparam int     VEL_MIN     = -65536;

    function automatic logic signed [CZW-1:0] atan_q30(input int idx);
        logic signed [CZW-1:0] res;
        case (idx)
            0:  res = CZW'(843314856);
            1:  res = CZW'(497837829);
            2:  res = CZW'(263043836);
            3:  res = CZW'(133525158);
            4:  res = CZW'(67021686);
            5:  res = CZW'(33543515);
            6:  res = CZW'(16775850);
            7:  res = CZW'(8388437);
            8:  res = CZW'(4194282);
            9:  res = CZW'(2097149);
            10: res = CZW'(1048575);
            11: res = CZW'(524287);
            12: res = CZW'(262143);
            13: res = CZW'(131071);
            14: res = CZW'(65535);
            15: res = CZW'(32767);
            16: res = CZW'(16383);
            17: res = CZW'(8191);
            18: res = CZW'(4095);
            19: res = CZW'(2047);
            20: res = CZW'(1023);
            21: res = CZW'(511);
            22: res = CZW'(255);
            23: res = CZW'(127);
            24: res = CZW'(63);
            25: res = CZW'(31);
            26: res = CZW'(15);
            27: res = CZW'(8);
            28: res = CZW'(4);
            29: res = CZW'(2);
            default: res = '0;
        endcase
        return res;
    endfunction

    typedef struct packed {
        logic        neg;
        logic signed [CZW-1:0] z;
    } t_red;

    typedef struct packed {
        logic [15:0] tens;
        logic        atleast;
        logic        neg_t;
        logic        neg_f;
    } t_cside;

    typedef struct packed {
        logic signed [XW-1:0]  xt;
        logic signed [XW-1:0]  yt;
        logic signed [XW-1:0]  xf;
        logic signed [XW-1:0]  yf;
        logic signed [CZW-1:0] zt;
        logic signed [CZW-1:0] zf;
        t_cside                side;
    } t_cord;

    typedef struct packed {
        logic num_neg;
        logic den_bad;
        logic bound_en;
    } t_dside;

    typedef struct packed {
        logic [RW-1:0] rem_a;
        logic [RW-1:0] rem_b;
        logic [DW-1:0] d_a;
        logic [DW-1:0] d_b;
        logic [QW-1:0] q_a;
        logic [QW-1:0] q_b;
        t_dside        side;
    } t_div;

endpackage
`default_nettype wire

### sv/spline_control_velocity.sv
// Top level: angle reduction, CORDIC cell chain, velocity arithmetic, divider cell chain.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  input    | in        | i_valid / o_stall | i_theta, i_phi, i_tension_value,
//           |           |                   | i_tension_atleast
//  result   | out       | o_valid / i_stall | o_velocity, o_saturated
//
// One item per cycle unless the result is stalled; the pipe holds one reduction register,
// one cell per CORDIC rotation, five arithmetic stages, 18 divider cells and an output register.
// Reset clears only the valid bits of the stages.
// A stalled result freezes the whole pipe; o_stall rises only while a result is held.
`default_nettype none
module spline_control_velocity import scv_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_theta,
    input  logic signed [15:0] i_phi,
    input  logic        [15:0] i_tension_value,
    input  logic               i_tension_atleast,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [16:0] o_velocity,
    output logic               o_saturated
);

    localparam int     SH        = 30 - ANGLE_FRAC_BITS;
    localparam int     ZW        = (47 - ANGLE_FRAC_BITS > 36) ? 47 - ANGLE_FRAC_BITS : 36;
    localparam longint MAXQ      = (64'sd1 <<< (45 - ANGLE_FRAC_BITS)) / Q30_TWO_PI;
    localparam int     RED_STEPS = $clog2(MAXQ + 1);
    localparam int     NIT       = (TRIG_ITERATIONS < 30) ? TRIG_ITERATIONS : 30;
    localparam int     UW        = XW + 1;
    localparam int     DENW      = 36;
    localparam int     SNW       = 38;
    localparam int     NUMW      = 36;
    localparam int     RRW       = QW + 2;
    localparam logic signed [RRW-1:0] R_MAX = RRW'(VEL_MAX);
    localparam logic signed [RRW-1:0] R_MIN = RRW'(VEL_MIN);

    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // angle range reduction into [-pi/2, pi/2] with a sign fold
    function automatic t_red reduce(input logic signed [15:0] raw);
        logic signed [ZW-1:0] z;
        logic signed [ZW-1:0] tp;
        logic signed [ZW-1:0] p;
        logic signed [ZW-1:0] hp;
        logic        [ZW-1:0] a;
        t_red                 res;
        tp = ZW'(Q30_TWO_PI);
        p  = ZW'(Q30_PI);
        hp = ZW'(Q30_HALF_PI);
        z  = ZW'(raw) <<< SH;
        a  = z[ZW-1] ? ZW'(-z) : ZW'(z);
        for (int j = RED_STEPS - 1; j >= 0; j--) begin
            if (a >= (ZW'(Q30_TWO_PI) << j)) begin
                a = a - (ZW'(Q30_TWO_PI) << j);
            end
        end
        z = z[ZW-1] ? -$signed(a) : $signed(a);
        if (z > p) begin
            z = z - tp;
        end else if (z < -p) begin
            z = z + tp;
        end
        res.neg = 1'b0;
        if (z > hp) begin
            z       = z - p;
            res.neg = 1'b1;
        end else if (z < -hp) begin
            z       = z + p;
            res.neg = 1'b1;
        end
        res.z = z[CZW-1:0];
        return res;
    endfunction

    // ---------------- reduction register feeding the CORDIC chain
    t_cord cord   [NIT+1];
    logic  cord_v [NIT+1];
    t_cord n_c0;
    t_cord r_c0;
    logic  r_c0_valid;
    t_red  red_t;
    t_red  red_f;

    always_comb begin
        red_t            = reduce(i_theta);
        red_f            = reduce(i_phi);
        n_c0.xt          = XW'(Q30_GAIN);
        n_c0.yt          = '0;
        n_c0.xf          = XW'(Q30_GAIN);
        n_c0.yf          = '0;
        n_c0.zt          = red_t.z;
        n_c0.zf          = red_f.z;
        n_c0.side.tens    = i_tension_value;
        n_c0.side.atleast = i_tension_atleast;
        n_c0.side.neg_t   = red_t.neg;
        n_c0.side.neg_f   = red_f.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0_valid <= 1'b0;
        end else if (en) begin
            r_c0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0 <= n_c0;
        end
    end

    assign cord[0]   = r_c0;
    assign cord_v[0] = r_c0_valid;

    for (genvar k = 0; k < NIT; k++) begin : g_cordic
        scv_cordic_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cord_v[k]),
            .i_data  (cord[k]),
            .o_valid (cord_v[k+1]),
            .o_data  (cord[k+1])
        );
    end

    // ---------------- stage A: differences and first products
    logic signed [XW-1:0] st, ct, sf, cf;
    assign st = cord[NIT].side.neg_t ? -cord[NIT].yt : cord[NIT].yt;
    assign ct = cord[NIT].side.neg_t ? -cord[NIT].xt : cord[NIT].xt;
    assign sf = cord[NIT].side.neg_f ? -cord[NIT].yf : cord[NIT].yf;
    assign cf = cord[NIT].side.neg_f ? -cord[NIT].xf : cord[NIT].xf;

    logic                   r_a_valid;
    logic signed [UW-1:0]   r_a_u, r_a_v, r_a_w;
    logic signed [63:0]     r_a_p1, r_a_p2;
    logic signed [2*XW-1:0] r_a_q1, r_a_q2;
    logic signed [XW-1:0]   r_a_sf;
    logic                   r_a_st_neg, r_a_st_zero, r_a_atleast;
    logic [15:0]            r_a_tens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= cord_v[NIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_u       <= UW'(st) - UW'(sf >>> 4);
            r_a_v       <= UW'(sf) - UW'(st >>> 4);
            r_a_w       <= UW'(ct) - UW'(cf);
            r_a_p1      <= $signed(32'(Q30_CHALF)) * ct;
            r_a_p2      <= $signed(32'(Q30_DHALF)) * cf;
            r_a_q1      <= st * cf;
            r_a_q2      <= ct * sf;
            r_a_sf      <= sf;
            r_a_st_neg  <= st[XW-1];
            r_a_st_zero <= (st == '0);
            r_a_atleast <= cord[NIT].side.atleast;
            r_a_tens    <= cord[NIT].side.tens;
        end
    end

    // ---------------- stage B: u*v, denominator sum, sine of the sum
    logic                   r_b_valid;
    logic signed [2*UW-1:0] r_b_uv;
    logic signed [UW-1:0]   r_b_w;
    logic signed [DENW-1:0] r_b_den;
    logic signed [SNW-1:0]  r_b_sine;
    logic signed [XW-1:0]   r_b_sf;
    logic                   r_b_st_neg, r_b_st_zero, r_b_atleast;
    logic [15:0]            r_b_tens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_uv      <= r_a_u * r_a_v;
            r_b_w       <= r_a_w;
            r_b_den     <= DENW'(64'(Q30_ONE) + (r_a_p1 >>> 30) + (r_a_p2 >>> 30));
            r_b_sine    <= SNW'((r_a_q1 + r_a_q2) >>> 30);
            r_b_sf      <= r_a_sf;
            r_b_st_neg  <= r_a_st_neg;
            r_b_st_zero <= r_a_st_zero;
            r_b_atleast <= r_a_atleast;
            r_b_tens    <= r_a_tens;
        end
    end

    // ---------------- stage C: times (ct - cf), 3*den, bound operands
    logic signed [UW-1:0] uvs;
    logic                 bound_c;
    logic [XW-1:0]        abs_sf;
    logic [SNW-1:0]       abs_sine;

    always_comb begin
        uvs      = UW'(r_b_uv >>> 30);
        abs_sf   = r_b_sf[XW-1] ? XW'(-r_b_sf) : XW'(r_b_sf);
        abs_sine = r_b_sine[SNW-1] ? SNW'(-r_b_sine) : SNW'(r_b_sine);
        bound_c  = r_b_atleast &&
                   ((!r_b_st_neg && !r_b_sf[XW-1] && (r_b_sine > 0)) ||
                    ((r_b_st_neg || r_b_st_zero) && (r_b_sf[XW-1] || (r_b_sf == '0)) &&
                     (r_b_sine < 0)));
    end

    logic                   r_c_valid;
    logic signed [2*UW-1:0] r_c_n1;
    logic signed [DENW+1:0] r_c_den3;
    logic [15:0]            r_c_tens;
    logic                   r_c_bound;
    logic [RW-1:0]          r_c_nb;
    logic [DW-1:0]          r_c_db;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_n1    <= uvs * r_b_w;
            r_c_den3  <= (DENW+2)'(r_b_den) * 3;
            r_c_tens  <= r_b_tens;
            r_c_bound <= bound_c;
            r_c_nb    <= RW'(abs_sf) << 13;
            r_c_db    <= DW'(abs_sine);
        end
    end

    // ---------------- stage D: times sqrt2, times tension
    logic signed [UW:0]     n1s;
    assign n1s = (UW+1)'(r_c_n1 >>> 30);

    logic                   r_d_valid;
    logic signed [UW+32:0]  r_d_n2;
    logic signed [DW:0]     r_d_den42;
    logic                   r_d_bound;
    logic [RW-1:0]          r_d_nb;
    logic [DW-1:0]          r_d_db;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_n2    <= n1s * $signed(32'(Q30_SQRT2));
            r_d_den42 <= (DW+1)'(r_c_den3) * (DW+1)'($signed({1'b0, r_c_tens}));
            r_d_bound <= r_c_bound;
            r_d_nb    <= r_c_nb;
            r_d_db    <= r_c_db;
        end
    end

    // ---------------- stage E: numerator, dividend set-up
    logic signed [NUMW-1:0] num;
    logic [NUMW-1:0]        abs_num;
    logic                   den_bad;
    t_div                   n_div0;

    always_comb begin
        num     = NUMW'(r_d_n2 >>> 30) + NUMW'(2 * Q30_ONE);
        abs_num = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        den_bad = (r_d_den42 <= 0);
        n_div0.rem_a         = RW'(abs_num) << 25;
        n_div0.d_a           = den_bad ? DW'(1) : r_d_den42[DW-1:0];
        n_div0.rem_b         = r_d_nb;
        n_div0.d_b           = r_d_db;
        n_div0.q_a           = '0;
        n_div0.q_b           = '0;
        n_div0.side.num_neg  = num[NUMW-1];
        n_div0.side.den_bad  = den_bad;
        n_div0.side.bound_en = r_d_bound;
    end

    t_div div   [QW+1];
    logic div_v [QW+1];
    t_div r_div0;
    logic r_div0_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div0_valid <= 1'b0;
        end else if (en) begin
            r_div0_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div0 <= n_div0;
        end
    end

    assign div[0]   = r_div0;
    assign div_v[0] = r_div0_valid;

    // first cell (top bit) catches quotients beyond the clamp range
    for (genvar k = 0; k < QW; k++) begin : g_div
        scv_div_cell #(.J(QW - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_v[k]),
            .i_data  (div[k]),
            .o_valid (div_v[k+1]),
            .o_data  (div[k+1])
        );
    end

    // ---------------- output register: sign, clamps, at-least bound
    logic signed [RRW-1:0] ra;
    logic signed [RRW-1:0] rb;
    logic                  n_sat;

    always_comb begin
        rb    = $signed({2'b00, div[QW].q_b});
        ra    = div[QW].side.num_neg ? -$signed({2'b00, div[QW].q_a})
                                     : $signed({2'b00, div[QW].q_a});
        n_sat = div[QW].side.den_bad;
        if (div[QW].side.den_bad) begin
            ra = R_MAX;
        end
        if (ra > R_MAX) begin
            ra = R_MAX;
        end
        if (div[QW].side.bound_en && (ra > rb)) begin
            ra = rb;
        end
        if (ra < R_MIN) begin
            ra    = R_MIN;
            n_sat = 1'b1;
        end
    end

    logic               r_out_valid;
    logic signed [16:0] r_vel;
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vel <= ra[16:0];
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_velocity  = r_vel;
    assign o_saturated = r_sat;

    // ---------------- assertions
    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall raised without a held result");

    a_upper_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_velocity <= 17'sd32768))
        else $error("velocity above upper clamp");

    a_den_bad_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && div_v[QW] && div[QW].side.den_bad) |=> (o_valid && o_saturated))
        else $error("bad denominator not flagged");

endmodule
`default_nettype wire

### sv/scv_cordic_cell.sv
// One CORDIC rotation cell, both angle lanes, registered.
`default_nettype none
module scv_cordic_cell import scv_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_cord i_data,
    output logic  o_valid,
    output t_cord o_data
);

    localparam logic signed [CZW-1:0] ANG = atan_q30(IDX);

    t_cord n_data;
    t_cord r_data;
    logic  r_valid;

    always_comb begin
        n_data = i_data;
        if (!i_data.zt[CZW-1]) begin
            n_data.xt = i_data.xt - (i_data.yt >>> IDX);
            n_data.yt = i_data.yt + (i_data.xt >>> IDX);
            n_data.zt = i_data.zt - ANG;
        end else begin
            n_data.xt = i_data.xt + (i_data.yt >>> IDX);
            n_data.yt = i_data.yt - (i_data.xt >>> IDX);
            n_data.zt = i_data.zt + ANG;
        end
        if (!i_data.zf[CZW-1]) begin
            n_data.xf = i_data.xf - (i_data.yf >>> IDX);
            n_data.yf = i_data.yf + (i_data.xf >>> IDX);
            n_data.zf = i_data.zf - ANG;
        end else begin
            n_data.xf = i_data.xf + (i_data.yf >>> IDX);
            n_data.yf = i_data.yf - (i_data.xf >>> IDX);
            n_data.zf = i_data.zf + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### sv/scv_div_cell.sv
// One restoring-division cell: one quotient bit for both quotient lanes, registered.
`default_nettype none
module scv_div_cell import scv_pkg::*; #(
    parameter int J = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_valid,
    output t_div o_data
);

    t_div          n_data;
    t_div          r_data;
    logic          r_valid;
    logic [RW-1:0] sd_a;
    logic [RW-1:0] sd_b;

    always_comb begin
        sd_a   = RW'(i_data.d_a) << J;
        sd_b   = RW'(i_data.d_b) << J;
        n_data = i_data;
        if (i_data.rem_a >= sd_a) begin
            n_data.rem_a  = i_data.rem_a - sd_a;
            n_data.q_a[J] = 1'b1;
        end
        if (i_data.rem_b >= sd_b) begin
            n_data.rem_b  = i_data.rem_b - sd_b;
            n_data.q_b[J] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire
